[src/packet_descriptor_ring_top_assert.svh]
// assertion macros used by the checker file
`ifndef PACKET_DESCRIPTOR_RING_TOP_ASSERT_SVH
`define PACKET_DESCRIPTOR_RING_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PDR_ASSERT_NOW(label, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PDR_ASSERT_NEXT(label, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

[src/pdr_pkg.sv]
package pdr_pkg;

  localparam int SLOTS      = 16;
  localparam int BUF_BYTES  = 65536;
  localparam int MAX_PACKET = 16384;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int OFF_W  = $clog2(BUF_BYTES);
  localparam int LEN_W  = 15;
  localparam int IN_LEN_W = 16;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_LEN   = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;
  localparam logic [1:0] STAT_TOO_SMALL = 2'd3;

  typedef struct packed {
    logic                kind;
    logic [IN_LEN_W-1:0] length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [15:0] byte_offset;
    logic [14:0] packet_length;
    logic [4:0]  occupancy;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic set_bad;
    logic do_write;
    logic do_release;
    logic set_empty;
    logic scan_start;
    logic scan_step;
    logic mem_read;
    logic set_hit;
    logic out_load;
  } pdr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_len;
    logic is_read;
    logic count_zero;
    logic scan_hit;
    logic out_free;
  } pdr_stat_t;

  function automatic logic [SLOT_W-1:0] next_index(input logic [SLOT_W-1:0] i);
    logic [SLOT_W-1:0] r;
    if (i == SLOT_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = i + SLOT_W'(1);
    end
    return r;
  endfunction

endpackage

[src/pdr_ctrl.sv]
module pdr_ctrl
  import pdr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pdr_stat_t stat,
  output pdr_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FETCH  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.bad_len) begin
          cmd.set_bad = 1'b1;
          state_nxt   = S_FINISH;
        end else if (!stat.is_read) begin
          cmd.do_write = 1'b1;
          state_nxt    = S_FINISH;
        end else begin
          cmd.do_release = 1'b1;
          state_nxt      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.count_zero) begin
          cmd.set_empty = 1'b1;
          state_nxt     = S_FINISH;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        // count is nonzero, so some slot is valid and the walk ends
        if (stat.scan_hit) begin
          cmd.mem_read = 1'b1;
          state_nxt    = S_FETCH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FETCH: begin
        cmd.set_hit = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[src/pdr_datapath.sv]
module pdr_datapath
  import pdr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  pdr_cmd_t  cmd,
  output pdr_stat_t stat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // descriptor store
  logic [OFF_W-1:0] off_mem [SLOTS];
  logic [LEN_W-1:0] len_mem [SLOTS];
  logic [OFF_W-1:0] rd_off_r;
  logic [LEN_W-1:0] rd_len_r;

  logic [SLOTS-1:0]    valid_r;
  logic [SLOTS-1:0]    valid_nxt;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [SLOT_W-1:0]   write_slot_r;
  logic [SLOT_W-1:0]   read_slot_r;
  logic                held_valid_r;
  logic [SLOT_W-1:0]   held_idx_r;
  logic [OFF_W-1:0]    write_offset_r;
  logic [SLOT_W-1:0]   scan_idx_r;

  logic                kind_r;
  logic [IN_LEN_W-1:0] len_r;

  logic [1:0]          res_status_r;
  logic [SLOT_W-1:0]   res_slot_r;
  logic [OFF_W-1:0]    res_off_r;
  logic [LEN_W-1:0]    res_len_r;

  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [SLOT_W-1:0]   wr_idx;
  logic [OFF_W:0]      off_sum;
  logic [OFF_W-1:0]    wr_base;
  logic [OFF_W:0]      end_sum;
  logic [OFF_W-1:0]    write_offset_nxt;

  assign stat.bad_len    = (len_r == '0) ||
                           ({1'b0, len_r} > (IN_LEN_W + 1)'(MAX_PACKET));
  assign stat.is_read    = (kind_r == KIND_READ);
  assign stat.count_zero = (count_r == '0);
  assign stat.scan_hit   = valid_r[scan_idx_r];
  assign stat.out_free   = !out_valid_r || out_ready;

  // write placement: step past the held slot, wrap to offset zero if it does not fit
  assign wr_idx  = (held_valid_r && (write_slot_r == held_idx_r)) ?
                   next_index(write_slot_r) : write_slot_r;
  assign off_sum = (OFF_W + 1)'(write_offset_r) + (OFF_W + 1)'(len_r);
  assign wr_base = (off_sum > (OFF_W + 1)'(BUF_BYTES)) ? '0 : write_offset_r;
  assign end_sum = (OFF_W + 1)'(wr_base) + (OFF_W + 1)'(len_r);
  assign write_offset_nxt = (end_sum >= (OFF_W + 1)'(BUF_BYTES)) ?
                            OFF_W'(end_sum - (OFF_W + 1)'(BUF_BYTES)) :
                            OFF_W'(end_sum);

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (cmd.do_write) begin
      valid_nxt[wr_idx] = 1'b1;
      if (!valid_r[wr_idx]) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (cmd.do_release && held_valid_r) begin
      valid_nxt[held_idx_r] = 1'b0;
      if (valid_r[held_idx_r]) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r        <= '0;
      count_r        <= '0;
      write_slot_r   <= '0;
      read_slot_r    <= '0;
      held_valid_r   <= 1'b0;
      held_idx_r     <= '0;
      write_offset_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      if (cmd.do_write) begin
        write_slot_r   <= next_index(wr_idx);
        write_offset_r <= write_offset_nxt;
      end
      if (cmd.do_release) begin
        held_valid_r <= 1'b0;
      end
      if (cmd.set_hit) begin
        read_slot_r  <= next_index(scan_idx_r);
        held_valid_r <= 1'b1;
        held_idx_r   <= scan_idx_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_write) begin
      off_mem[wr_idx] <= wr_base;
      len_mem[wr_idx] <= len_r[LEN_W-1:0];
    end
    if (cmd.mem_read) begin
      rd_off_r <= off_mem[scan_idx_r];
      rd_len_r <= len_mem[scan_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= in_data.kind;
      len_r  <= in_data.length;
    end
    if (cmd.scan_start) begin
      scan_idx_r <= read_slot_r;
    end else if (cmd.scan_step) begin
      scan_idx_r <= next_index(scan_idx_r);
    end
    if (cmd.set_bad || cmd.set_empty) begin
      res_status_r <= cmd.set_bad ? STAT_BAD_LEN : STAT_EMPTY;
      res_slot_r   <= '0;
      res_off_r    <= '0;
      res_len_r    <= '0;
    end else if (cmd.do_write) begin
      res_status_r <= STAT_OK;
      res_slot_r   <= wr_idx;
      res_off_r    <= wr_base;
      res_len_r    <= len_r[LEN_W-1:0];
    end else if (cmd.set_hit) begin
      res_status_r <= (len_r >= (IN_LEN_W)'(rd_len_r)) ? STAT_OK : STAT_TOO_SMALL;
      res_slot_r   <= scan_idx_r;
      res_off_r    <= rd_off_r;
      res_len_r    <= rd_len_r;
    end
    if (cmd.out_load) begin
      out_data_r.status        <= res_status_r;
      out_data_r.slot          <= 4'(res_slot_r);
      out_data_r.byte_offset   <= 16'(res_off_r);
      out_data_r.packet_length <= res_len_r;
      out_data_r.occupancy     <= 5'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/packet_descriptor_ring_top.sv]
// channel  ports                          beat contents
// input    in_valid/in_ready/in_data     kind, length
// output   out_valid/out_ready/out_data  status, slot, byte_offset, packet_length, occupancy
//
// one item at a time: a bad length or a write goes through idle, decode and finish; a read
// also passes check and, unless the ring is empty, scan and fetch, stepping over 0..15 slots
// from the read pointer, as the slot walk checks one valid bit per cycle
// synchronous active-low reset clears all valid bits, pointers and the count
// a finished result sits in the output register; the next item is accepted meanwhile
// and only its own result waits for out_ready
module packet_descriptor_ring_top
  import pdr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  pdr_cmd_t  cmd;
  pdr_stat_t stat;

  pdr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pdr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[src/pdr_checker.sv]
`include "packet_descriptor_ring_top_assert.svh"

module pdr_checker
  import pdr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled input beat holds
  `PDR_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data), "input beat changed while stalled")

  // a stalled result beat holds
  `PDR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

  // error and empty results carry no descriptor
  `PDR_ASSERT_NOW(a_no_desc, out_valid && (out_data.status == STAT_BAD_LEN || out_data.status == STAT_EMPTY), out_data.slot == '0 && out_data.byte_offset == '0 && out_data.packet_length == '0, "descriptor fields set on error or empty")

  // a reported descriptor has a legal length
  `PDR_ASSERT_NOW(a_desc_len, out_valid && (out_data.status == STAT_OK || out_data.status == STAT_TOO_SMALL), out_data.packet_length != '0 && out_data.packet_length <= 15'(MAX_PACKET), "descriptor length out of range")

  // occupancy never exceeds the ring size
  `PDR_ASSERT_NOW(a_occ_max, out_valid, out_data.occupancy <= 5'(SLOTS), "occupancy above slot count")

endmodule

bind packet_descriptor_ring_top pdr_checker u_pdr_checker (.*);
